// ===== src/dsm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the duration statistics monitor.
// Used by the controller, the datapath and the top level; no dependencies.
package dsm_pkg;

    localparam int DUR_W  = 32;
    localparam int SUM_W  = 48;
    localparam int HITS_W = 32;
    localparam int CNT_W  = 16;
    localparam int MODE_W = 2;
    localparam int PCT_W  = 7;
    localparam int FAC_W  = CNT_W + 1;
    localparam int DH_W   = DUR_W + HITS_W;
    localparam int LHS_W  = DH_W + PCT_W;
    localparam int RHS_W  = SUM_W + FAC_W;
    localparam int OUT_W  = HITS_W + SUM_W + DUR_W + DUR_W;

    localparam logic [PCT_W-1:0] PCT_BASE = PCT_W'(100);

    localparam logic [MODE_W-1:0] MODE_CUMULATIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTERVAL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABOVE_AVG  = 2'd2;

    localparam logic CFG_STAT_MODE       = 1'b0;
    localparam logic CFG_REPORT_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_CMP
    } t_state;

    typedef struct packed {
        logic update;
        logic mul1;
        logic mul2;
        logic finish;
    } t_dp_cmd;

endpackage

// ===== src/dsm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the duration statistics monitor: sequences update,
// multiply and finish steps and owns the output valid flag. Uses dsm_pkg.
module dsm_ctrl import dsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [MODE_W-1:0] i_stat_mode,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output t_dp_cmd           o_cmd
);

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_stat_mode == MODE_ABOVE_AVG) ? S_MUL1 : S_CMP;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_CMP;
            S_CMP: begin
                if (!r_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready    = (r_state == S_IDLE);
        o_cmd.update  = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.mul1    = (r_state == S_MUL1);
        o_cmd.mul2    = (r_state == S_MUL2);
        // hold the finished item until the output register is free
        o_cmd.finish  = (r_state == S_CMP) && (!r_valid || i_m_tready);
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd.finish) begin
            n_valid = 1'b1;
        end else if (r_valid && i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_m_tvalid = r_valid;

endmodule

// ===== src/dsm_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the duration statistics monitor: running statistics, the
// above-average products and the output register. Uses dsm_pkg.
module dsm_dp import dsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [MODE_W-1:0] i_stat_mode,
    input  logic [CNT_W-1:0]  i_report_interval,
    input  logic [DUR_W-1:0]  i_duration,
    output logic              o_report,
    output logic [OUT_W-1:0]  o_snapshot
);

    logic [SUM_W-1:0]  r_sum;
    logic [DUR_W-1:0]  r_min;
    logic [DUR_W-1:0]  r_max;
    logic [HITS_W-1:0] r_hits;
    logic [CNT_W-1:0]  r_since;
    logic [DUR_W-1:0]  r_dur;

    logic [DH_W-1:0]   r_dh;
    logic [RHS_W-1:0]  r_rhs;
    logic [LHS_W-1:0]  r_lhs;

    logic              r_out_report;
    logic [OUT_W-1:0]  r_out_data;

    logic [SUM_W:0]    n_sum_wide;
    logic [SUM_W-1:0]  n_sum;
    logic [FAC_W-1:0]  rhs_factor;
    logic              report;

    always_comb begin
        n_sum_wide = {1'b0, r_sum} + (SUM_W+1)'(i_duration);
        // saturate on carry out of the sum
        n_sum      = n_sum_wide[SUM_W] ? '1 : n_sum_wide[SUM_W-1:0];
        rhs_factor = FAC_W'(PCT_BASE) + FAC_W'(i_report_interval);
        if (i_stat_mode == MODE_ABOVE_AVG) begin
            report = (r_lhs > LHS_W'(r_rhs));
        end else begin
            report = (r_since == i_report_interval);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_hits  <= '0;
            r_since <= '0;
        end else if (i_cmd.update) begin
            r_sum   <= n_sum;
            if (i_duration < r_min) begin
                r_min <= i_duration;
            end
            if (i_duration > r_max) begin
                r_max <= i_duration;
            end
            if (r_hits != '1) begin
                r_hits <= r_hits + HITS_W'(1);
            end
            r_since <= r_since + CNT_W'(1);
        end else if (i_cmd.finish && report) begin
            r_since <= '0;
            if (i_stat_mode == MODE_INTERVAL) begin
                r_sum <= '0;
                r_max <= '0;
                r_min <= '1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_dur <= i_duration;
        end
        if (i_cmd.mul1) begin
            r_dh  <= DH_W'(r_dur) * DH_W'(r_hits);
            r_rhs <= RHS_W'(r_sum) * RHS_W'(rhs_factor);
        end
        if (i_cmd.mul2) begin
            r_lhs <= LHS_W'(r_dh) * LHS_W'(PCT_BASE);
        end
        if (i_cmd.finish) begin
            // snapshot shows the statistics before any interval clear
            r_out_report <= report;
            r_out_data   <= {r_max, r_min, r_sum, r_hits};
        end
    end

    assign o_report   = r_out_report;
    assign o_snapshot = r_out_data;

endmodule

// ===== src/duration_statistics_monitor.sv =====
`timescale 1ns / 1ps
// Duration statistics monitor top level: configuration registers and the
// controller and datapath instances. Depends on dsm_pkg, dsm_ctrl, dsm_dp.
// The result is registered after the input item is accepted; cumulative modes
// pass through the compare state, above-average mode through the two registered
// multiply steps and then the compare state, which waits while the output
// register is full. A new item is taken only when idle, after the last result.
// Reset (synchronous, active low) clears statistics, mode and sets interval 1.
module duration_statistics_monitor import dsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DUR_W-1:0]  i_s_tdata,   // [31:0] duration
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,   // [31:0] snap_hits, [79:32] snap_sum,
                                           // [111:80] snap_min, [143:112] snap_max
    output logic              o_m_tuser    // [0] report
);

    logic [MODE_W-1:0] r_stat_mode;
    logic [CNT_W-1:0]  r_report_interval;
    t_dp_cmd           cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat_mode       <= MODE_CUMULATIVE;
            r_report_interval <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STAT_MODE:       r_stat_mode       <= i_cfg_data[MODE_W-1:0];
                CFG_REPORT_INTERVAL: r_report_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat_mode (r_stat_mode),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_cmd       (cmd)
    );

    dsm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_stat_mode       (r_stat_mode),
        .i_report_interval (r_report_interval),
        .i_duration        (i_s_tdata),
        .o_report          (o_m_tuser),
        .o_snapshot        (o_m_tdata)
    );

endmodule
